@@ hw/rtl/icmp_probe_reply_classifier_macros.svh @@
// Assertion macros for the probe reply classifier
`ifndef ICMP_PROBE_REPLY_CLASSIFIER_MACROS_SVH
`define ICMP_PROBE_REPLY_CLASSIFIER_MACROS_SVH

// same-cycle implication, off during reset
`define IPRC_ASSERT_NOW(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("iprc assertion failed");

// next-cycle implication, off during reset
`define IPRC_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("iprc assertion failed");

// next-cycle implication, always on
`define IPRC_ASSERT_NEXT_ALWAYS(name, clk, pre, post) \
    name: assert property (@(posedge clk) (pre) |=> (post)) \
        else $error("iprc assertion failed");

`endif

@@ hw/rtl/iprc_pkg.sv @@
`default_nettype none

package iprc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MSG_HDR_LEN  = 8;
    localparam int QUOTE_MINLEN = 16;
    localparam int TTL_OFFSET   = 8;
    localparam int PROTO_OFFSET = 9;

    localparam logic [7:0] TYPE_ECHO_REPLY     = 8'd0;
    localparam logic [7:0] TYPE_DEST_UNREACH   = 8'd3;
    localparam logic [7:0] TYPE_TIME_EXCEEDED  = 8'd11;
    localparam logic [7:0] CODE_TTL_IN_TRANSIT = 8'd0;
    localparam logic [7:0] CODE_FRAG_NEEDED    = 8'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CHECK_MODE     = 3'd0,
        CFG_PROTO_NUMBER   = 3'd1,
        CFG_IDENT          = 3'd2,
        CFG_BASE_PORT      = 3'd3,
        CFG_SEQ_ON_SRC     = 3'd4,
        CFG_SCTP_SHORT_TAG = 3'd5
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_UDP     = 3'd0,
        MODE_TCP     = 3'd1,
        MODE_SCTP    = 3'd2,
        MODE_ECHO    = 3'd3,
        MODE_GENERIC = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        VERDICT_IGNORE   = 2'd0,
        VERDICT_ECHO     = 2'd1,
        VERDICT_TIMXCEED = 2'd2,
        VERDICT_UNREACH  = 2'd3
    } t_verdict;

    localparam logic [2:0]  RST_CHECK_MODE     = 3'd0;
    localparam logic [7:0]  RST_PROTO_NUMBER   = 8'd17;
    localparam logic [15:0] RST_IDENT          = 16'd0;
    localparam logic [15:0] RST_BASE_PORT      = 16'd33434;
    localparam logic        RST_SEQ_ON_SRC     = 1'b0;
    localparam logic        RST_SCTP_SHORT_TAG = 1'b1;

    typedef struct packed {
        logic [2:0]  mode;
        logic [7:0]  proto;
        logic [15:0] ident;
        logic [15:0] base_port;
        logic        seq_on_src;
        logic        sctp_short_tag;
    } t_cfg;

    typedef struct packed {
        logic        last;
        logic [7:0]  seq;
        logic [15:0] idx;
        logic [5:0]  hl;
        logic [7:0]  ttl;
        logic [7:0]  itype;
        logic [7:0]  icode;
        logic [31:0] word;
        logic [5:0]  ihl;
        logic [7:0]  iproto;
        logic [63:0] xport;
    } t_capt;

    typedef struct packed {
        t_verdict    verdict;
        logic [7:0]  ucode;
        logic [15:0] mtu;
        logic [7:0]  ttl;
    } t_res;

endpackage

`default_nettype wire

@@ hw/rtl/iprc_if.sv @@
`default_nettype none

interface iprc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [iprc_pkg::CFG_IDX_W-1:0]   index;
    logic [iprc_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

interface iprc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       last_byte;
    logic [7:0] probe_seq;

    modport source (output valid, output rx_byte, output last_byte, output probe_seq,
                    input ready);
    modport sink   (input valid, input rx_byte, input last_byte, input probe_seq,
                    output ready);
endinterface

interface iprc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  verdict;
    logic [7:0]  unreach_code;
    logic [15:0] next_mtu;
    logic [7:0]  reply_ttl;

    modport source (output valid, output verdict, output unreach_code, output next_mtu,
                    output reply_ttl, input ready);
    modport sink   (input valid, input verdict, input unreach_code, input next_mtu,
                    input reply_ttl, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/iprc_cfg_regs.sv @@
`default_nettype none

module iprc_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    iprc_cfg_if.sink       s_cfg,
    output iprc_pkg::t_cfg o_cfg
);

    iprc_pkg::t_cfg r_cfg;

    assign s_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= iprc_pkg::RST_CHECK_MODE;
            r_cfg.proto          <= iprc_pkg::RST_PROTO_NUMBER;
            r_cfg.ident          <= iprc_pkg::RST_IDENT;
            r_cfg.base_port      <= iprc_pkg::RST_BASE_PORT;
            r_cfg.seq_on_src     <= iprc_pkg::RST_SEQ_ON_SRC;
            r_cfg.sctp_short_tag <= iprc_pkg::RST_SCTP_SHORT_TAG;
        end else if (s_cfg.valid) begin
            case (s_cfg.index)
                iprc_pkg::CFG_CHECK_MODE:     r_cfg.mode           <= s_cfg.data[2:0];
                iprc_pkg::CFG_PROTO_NUMBER:   r_cfg.proto          <= s_cfg.data[7:0];
                iprc_pkg::CFG_IDENT:          r_cfg.ident          <= s_cfg.data[15:0];
                iprc_pkg::CFG_BASE_PORT:      r_cfg.base_port      <= s_cfg.data[15:0];
                iprc_pkg::CFG_SEQ_ON_SRC:     r_cfg.seq_on_src     <= s_cfg.data[0];
                iprc_pkg::CFG_SCTP_SHORT_TAG: r_cfg.sctp_short_tag <= s_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/iprc_capture.sv @@
`default_nettype none

module iprc_capture (
    input  logic            i_clk,
    input  logic            i_rst_n,
    iprc_in_if.sink         s_in,
    input  logic            i_out_free,
    output logic            o_fire,
    output iprc_pkg::t_capt o_capt
);

    logic        r_vld;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [7:0]  r_seq;

    logic [15:0] r_cnt;
    logic [5:0]  r_hl;
    logic [7:0]  r_ttl;
    logic [7:0]  r_type;
    logic [7:0]  r_code;
    logic [31:0] r_word;
    logic [5:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [63:0] r_xport;

    logic [15:0] n_cnt;
    logic [5:0]  n_hl;
    logic [7:0]  n_ttl;
    logic [7:0]  n_type;
    logic [7:0]  n_code;
    logic [31:0] n_word;
    logic [5:0]  n_ihl;
    logic [7:0]  n_proto;
    logic [63:0] n_xport;

    logic [15:0] off;
    logic [15:0] q;
    logic [15:0] p;
    logic        in_icmp;
    logic        in_quote;
    logic        fire;

    assign fire        = r_vld && (!r_last || i_out_free);
    assign s_in.ready  = !r_vld || fire;
    assign o_fire      = fire;

    always_comb begin
        n_hl    = (r_cnt == 16'd0) ? {r_byte[3:0], 2'b00} : r_hl;
        n_ttl   = (r_cnt == 16'(iprc_pkg::TTL_OFFSET)) ? r_byte : r_ttl;
        n_type  = r_type;
        n_code  = r_code;
        n_word  = r_word;
        n_ihl   = r_ihl;
        n_proto = r_proto;
        n_xport = r_xport;
        n_cnt   = (r_cnt != 16'hFFFF) ? r_cnt + 16'd1 : r_cnt;

        in_icmp  = r_cnt >= {10'd0, n_hl};
        off      = r_cnt - {10'd0, n_hl};
        in_quote = in_icmp && (off >= 16'(iprc_pkg::MSG_HDR_LEN));
        q        = off - 16'(iprc_pkg::MSG_HDR_LEN);

        if (in_icmp) begin
            if (off == 16'd0) begin
                n_type = r_byte;
            end else if (off == 16'd1) begin
                n_code = r_byte;
            end else if (off[15:2] == 14'd1) begin
                n_word[{~off[1:0], 3'b000} +: 8] = r_byte;
            end
        end

        if (in_quote && q == 16'd0) begin
            n_ihl = {r_byte[3:0], 2'b00};
        end
        p = q - {10'd0, n_ihl};
        if (in_quote && q == 16'(iprc_pkg::PROTO_OFFSET)) begin
            n_proto = r_byte;
        end
        if (in_quote && q >= {10'd0, n_ihl} && p[15:3] == 13'd0) begin
            n_xport[{~p[2:0], 3'b000} +: 8] = r_byte;
        end
    end

    always_comb begin
        o_capt.last   = r_last;
        o_capt.seq    = r_seq;
        o_capt.idx    = r_cnt;
        o_capt.hl     = n_hl;
        o_capt.ttl    = n_ttl;
        o_capt.itype  = n_type;
        o_capt.icode  = n_code;
        o_capt.word   = n_word;
        o_capt.ihl    = n_ihl;
        o_capt.iproto = n_proto;
        o_capt.xport  = n_xport;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_in.valid && s_in.ready) begin
            r_vld <= 1'b1;
        end else if (fire) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_in.valid && s_in.ready) begin
            r_byte <= s_in.rx_byte;
            r_last <= s_in.last_byte;
            r_seq  <= s_in.probe_seq;
        end
    end

    // clear per-packet state on reset and on the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_last)) begin
            r_cnt   <= '0;
            r_hl    <= '0;
            r_ttl   <= '0;
            r_type  <= '0;
            r_code  <= '0;
            r_word  <= '0;
            r_ihl   <= '0;
            r_proto <= '0;
            r_xport <= '0;
        end else if (fire) begin
            r_cnt   <= n_cnt;
            r_hl    <= n_hl;
            r_ttl   <= n_ttl;
            r_type  <= n_type;
            r_code  <= n_code;
            r_word  <= n_word;
            r_ihl   <= n_ihl;
            r_proto <= n_proto;
            r_xport <= n_xport;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/iprc_classify.sv @@
`default_nettype none

module iprc_classify (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  iprc_pkg::t_cfg  i_cfg,
    input  logic            i_fire,
    input  iprc_pkg::t_capt i_capt,
    output logic            o_out_free,
    iprc_out_if.source      m_out
);

    logic           r_vld;
    iprc_pkg::t_res r_res;
    iprc_pkg::t_res n_res;

    logic [15:0] seq16;
    logic [15:0] bp_seq;
    logic [15:0] id_seq;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [31:0] w;
    logic [31:0] pw;
    logic [15:0] d;
    logic        ports_ok;
    logic        rule_ok;
    logic [16:0] len;
    logic        long_enough;
    logic        quote_ok;
    logic        echo_ok;
    logic        is_err;
    logic        is_timx;

    assign o_out_free = !r_vld || m_out.ready;

    always_comb begin
        seq16  = {8'd0, i_capt.seq};
        bp_seq = i_cfg.base_port + seq16;
        id_seq = i_cfg.ident + seq16;
        sp     = i_capt.xport[63:48];
        dp     = i_capt.xport[47:32];
        w      = i_capt.xport[31:0];
        pw     = i_capt.xport[63:32];
        d      = i_cfg.seq_on_src ? i_cfg.base_port : bp_seq;
        ports_ok = (sp == i_cfg.ident) && (dp == d);

        case (i_cfg.mode)
            iprc_pkg::MODE_UDP:
                rule_ok = (sp == (i_cfg.seq_on_src ? id_seq : i_cfg.ident)) && (dp == d);
            iprc_pkg::MODE_TCP:
                rule_ok = ports_ok && (w == pw);
            iprc_pkg::MODE_SCTP:
                rule_ok = ports_ok && (i_cfg.sctp_short_tag ? (w == pw) : (w == 32'd0));
            iprc_pkg::MODE_ECHO:
                rule_ok = (w[31:16] == i_cfg.ident) && (w[15:0] == seq16);
            iprc_pkg::MODE_GENERIC:
                rule_ok = (sp == i_cfg.ident) && (dp == bp_seq);
            default:
                rule_ok = 1'b0;
        endcase

        len         = {1'b0, i_capt.idx} + 17'd1;
        long_enough = len >= ({11'd0, i_capt.hl} + 17'(iprc_pkg::MSG_HDR_LEN));
        quote_ok    = ({11'd0, i_capt.ihl} + {11'd0, i_capt.hl}
                       + 17'(iprc_pkg::QUOTE_MINLEN)) <= len;
        echo_ok     = (i_capt.itype == iprc_pkg::TYPE_ECHO_REPLY)
                      && (i_cfg.mode == iprc_pkg::MODE_ECHO)
                      && (i_capt.word[31:16] == i_cfg.ident)
                      && (i_capt.word[15:0] == seq16);
        is_timx     = (i_capt.itype == iprc_pkg::TYPE_TIME_EXCEEDED);
        is_err      = (is_timx && i_capt.icode == iprc_pkg::CODE_TTL_IN_TRANSIT)
                      || (i_capt.itype == iprc_pkg::TYPE_DEST_UNREACH);

        n_res.verdict = iprc_pkg::VERDICT_IGNORE;
        n_res.ucode   = 8'd0;
        n_res.mtu     = 16'd0;
        n_res.ttl     = i_capt.ttl;
        if (long_enough) begin
            if (echo_ok) begin
                n_res.verdict = iprc_pkg::VERDICT_ECHO;
            end else if (is_err && quote_ok && (i_capt.iproto == i_cfg.proto) && rule_ok) begin
                if (is_timx) begin
                    n_res.verdict = iprc_pkg::VERDICT_TIMXCEED;
                end else begin
                    n_res.verdict = iprc_pkg::VERDICT_UNREACH;
                    n_res.ucode   = i_capt.icode;
                end
            end
            if (n_res.verdict != iprc_pkg::VERDICT_IGNORE
                && i_capt.icode == iprc_pkg::CODE_FRAG_NEEDED) begin
                n_res.mtu = i_capt.word[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_fire && i_capt.last) begin
            r_vld <= 1'b1;
        end else if (m_out.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && i_capt.last) begin
            r_res <= n_res;
        end
    end

    assign m_out.valid        = r_vld;
    assign m_out.verdict      = r_res.verdict;
    assign m_out.unreach_code = r_res.ucode;
    assign m_out.next_mtu     = r_res.mtu;
    assign m_out.reply_ttl    = r_res.ttl;

endmodule

`default_nettype wire

@@ hw/rtl/icmp_probe_reply_classifier.sv @@
// Path: a transferred byte is held in the input register and parsed as it
// leaves it, which also loads the result of a last byte into the output register.
// Throughput: one byte per cycle; a waiting result stalls only a last byte.
// Reset: i_rst_n low at a clock edge empties both registers, clears the
// per-packet capture state and loads the register defaults.
`default_nettype none

module icmp_probe_reply_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    iprc_cfg_if.sink    i_cfg,
    iprc_in_if.sink     i_in,
    iprc_out_if.source  o_out
);

    iprc_pkg::t_cfg  cfg;
    iprc_pkg::t_capt capt;
    logic            fire;
    logic            out_free;

    iprc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    iprc_capture u_capture (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (i_in),
        .i_out_free (out_free),
        .o_fire     (fire),
        .o_capt     (capt)
    );

    iprc_classify u_classify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_fire     (fire),
        .i_capt     (capt),
        .o_out_free (out_free),
        .m_out      (o_out)
    );

endmodule

`default_nettype wire

@@ hw/rtl/iprc_checker.sv @@
`default_nettype none
`include "icmp_probe_reply_classifier_macros.svh"

module iprc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_verdict,
    input  logic [7:0]  i_ucode,
    input  logic [15:0] i_mtu,
    input  logic [7:0]  i_ttl
);

    logic [33:0] payload;
    logic        out_stall;
    logic        out_ignore;
    logic        code_set;

    assign payload    = {i_verdict, i_ucode, i_mtu, i_ttl};
    assign out_stall  = i_out_valid && !i_out_ready;
    assign out_ignore = i_out_valid && (i_verdict == iprc_pkg::VERDICT_IGNORE);
    assign code_set   = i_out_valid && (i_ucode != 8'd0);

    `IPRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, i_out_valid && $stable(payload))
    `IPRC_ASSERT_NOW(a_ignore_clean, i_clk, i_rst_n, out_ignore, i_ucode == 8'd0 && i_mtu == 16'd0)
    `IPRC_ASSERT_NOW(a_code_unreach, i_clk, i_rst_n, code_set, i_verdict == iprc_pkg::VERDICT_UNREACH)
    `IPRC_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind icmp_probe_reply_classifier iprc_checker u_iprc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_verdict   (o_out.verdict),
    .i_ucode     (o_out.unreach_code),
    .i_mtu       (o_out.next_mtu),
    .i_ttl       (o_out.reply_ttl)
);

`default_nettype wire
